// ===== src/tpbs_pkg.sv =====
// Shared types, codes and constants of the timed packet burst sequencer.
package tpbs_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 20;
   localparam int SPAN_BITS         = 33;

   localparam logic [15:0] BLOCK_COUNT_RESET    = 16'd1;
   localparam logic [15:0] PACKETS_RESET        = 16'd1;
   localparam logic [15:0] INTERVAL_RESET       = 16'd1161;
   localparam logic [19:0] BLOCK_GAP_RESET      = 20'd0;
   localparam logic [7:0]  ALT_GROUP_RESET      = 8'd3;
   localparam logic [15:0] TX_TIMEOUT_RESET     = 16'd2000;
   localparam logic [31:0] NONE_MEASURED        = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_DONE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_BLOCK_COUNT = 3'd0,
      REG_PACKETS     = 3'd1,
      REG_INTERVAL    = 3'd2,
      REG_BLOCK_GAP   = 3'd3,
      REG_ALT_GROUP   = 3'd4,
      REG_TX_TIMEOUT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0]          block_count;
      logic [15:0]          packets_in_block;
      logic [15:0]          packet_interval_us;
      logic [19:0]          block_pause_us;
      logic [7:0]           alternate_group;
      logic [15:0]          tx_timeout_us;
      logic [SPAN_BITS-1:0] block_span_us;
   } cfg_type;

   typedef struct packed {
      logic        fire;
      logic        use_buffer_b;
      logic        base_change;
      logic        busy_res;
      logic        finished;
      logic [31:0] sent_count;
      logic [31:0] ok_count;
      logic [31:0] total_us;
      logic [31:0] period_min_us;
      logic [31:0] period_max_us;
   } rsp_type;

endpackage

// ===== src/tpbs_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
interface tpbs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic       tx_ok;

   modport source (output valid, output cmd, output tx_ok, input ready);
   modport sink   (input valid, input cmd, input tx_ok, output ready);
endinterface

interface tpbs_rsp_if;
   logic        valid;
   logic        ready;
   logic        fire;
   logic        use_buffer_b;
   logic        base_change;
   logic        busy_res;
   logic        finished;
   logic [31:0] sent_count;
   logic [31:0] ok_count;
   logic [31:0] total_us;
   logic [31:0] period_min_us;
   logic [31:0] period_max_us;

   modport source (output valid, output fire, output use_buffer_b, output base_change,
                   output busy_res, output finished, output sent_count, output ok_count,
                   output total_us, output period_min_us, output period_max_us,
                   input ready);
   modport sink   (input valid, input fire, input use_buffer_b, input base_change,
                   input busy_res, input finished, input sent_count, input ok_count,
                   input total_us, input period_min_us, input period_max_us,
                   output ready);
endinterface

// ===== src/tpbs_csr.sv =====
// Configuration registers and the registered block span derived from them.
module tpbs_csr
   import tpbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   localparam logic [SPAN_BITS-1:0] SPAN_RESET =
      SPAN_BITS'({16'd0, PACKETS_RESET} * {16'd0, INTERVAL_RESET}) + SPAN_BITS'(BLOCK_GAP_RESET);

   logic [15:0]          block_count_ff, block_count_in;
   logic [15:0]          packets_ff, packets_in;
   logic [15:0]          interval_ff, interval_in;
   logic [19:0]          gap_ff, gap_in;
   logic [7:0]           alt_group_ff, alt_group_in;
   logic [15:0]          timeout_ff, timeout_in;
   logic [SPAN_BITS-1:0] span_ff, span_in;

   always_comb begin
      block_count_in = block_count_ff;
      packets_in     = packets_ff;
      interval_in    = interval_ff;
      gap_in         = gap_ff;
      alt_group_in   = alt_group_ff;
      timeout_in     = timeout_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_BLOCK_COUNT: block_count_in = csr_wdata[15:0];
            REG_PACKETS:     packets_in     = csr_wdata[15:0];
            REG_INTERVAL:    interval_in    = csr_wdata[15:0];
            REG_BLOCK_GAP:   gap_in         = csr_wdata[19:0];
            REG_ALT_GROUP:   alt_group_in   = csr_wdata[7:0];
            REG_TX_TIMEOUT:  timeout_in     = csr_wdata[15:0];
            default:         ;
         endcase
      end
   end

   // time spanned by one block: its packets plus the gap, updated with its registers
   assign span_in = SPAN_BITS'({16'd0, packets_in} * {16'd0, interval_in})
                  + SPAN_BITS'(gap_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
         packets_ff     <= PACKETS_RESET;
         interval_ff    <= INTERVAL_RESET;
         gap_ff         <= BLOCK_GAP_RESET;
         alt_group_ff   <= ALT_GROUP_RESET;
         timeout_ff     <= TX_TIMEOUT_RESET;
         span_ff        <= SPAN_RESET;
      end else begin
         block_count_ff <= block_count_in;
         packets_ff     <= packets_in;
         interval_ff    <= interval_in;
         gap_ff         <= gap_in;
         alt_group_ff   <= alt_group_in;
         timeout_ff     <= timeout_in;
         span_ff        <= span_in;
      end
   end

   assign cfg.block_count        = block_count_ff;
   assign cfg.packets_in_block   = packets_ff;
   assign cfg.packet_interval_us = interval_ff;
   assign cfg.block_pause_us     = gap_ff;
   assign cfg.alternate_group    = alt_group_ff;
   assign cfg.tx_timeout_us      = timeout_ff;
   assign cfg.block_span_us      = span_ff;

endmodule

// ===== src/tpbs_step.sv =====
// Burst state registers and the combinational update for one command beat.
module tpbs_step
   import tpbs_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [1:0] cmd,
   input  logic       tx_ok,
   input  cfg_type    cfg,
   output rsp_type    result
);

   localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int SPAN_WIDE = (TIME_BITS > SPAN_BITS) ? TIME_BITS : SPAN_BITS;

   logic                 running_ff, running_in;
   logic                 awaiting_ff, awaiting_in;
   logic                 buf_b_ff, buf_b_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [15:0]          wait_ff, wait_in;
   logic [15:0]          block_idx_ff, block_idx_in;
   logic [15:0]          packet_idx_ff, packet_idx_in;
   logic [7:0]           group_pos_ff, group_pos_in;
   logic [TIME_BITS-1:0] block_start_ff, block_start_in;
   logic [TIME_BITS-1:0] next_due_ff, next_due_in;
   logic [TIME_BITS-1:0] last_fire_ff, last_fire_in;
   logic [31:0]          sent_ff, sent_in;
   logic [31:0]          ok_ff, ok_in;
   logic [31:0]          min_ff, min_in;
   logic [31:0]          max_ff, max_in;
   logic [31:0]          burst_ff, burst_in;

   logic                 fire, base_change, finished, ticked;
   logic [TIME_BITS-1:0] due_diff, fire_gap, span_t;
   logic [WIDE_BITS-1:0] gap_wide, elapsed_wide;
   logic [SPAN_WIDE-1:0] span_wide;
   logic [31:0]          gap32;
   logic [7:0]           group_size, group_base;
   logic [16:0]          packet_next;
   cmd_type              cmd_t;

   assign cmd_t     = cmd_type'(cmd);
   assign span_wide = SPAN_WIDE'(cfg.block_span_us);
   assign span_t    = span_wide[TIME_BITS-1:0];
   assign due_diff  = elapsed_ff - next_due_ff;
   assign fire_gap  = elapsed_ff - last_fire_ff;
   assign gap_wide  = WIDE_BITS'(fire_gap);
   // saturate fire-to-fire intervals that do not fit 32 bits
   assign gap32     = (gap_wide > WIDE_BITS'(NONE_MEASURED)) ? NONE_MEASURED
                                                             : gap_wide[31:0];
   assign group_size = (cfg.alternate_group != 8'd0) ? cfg.alternate_group : 8'd1;

   always_comb begin
      running_in     = running_ff;
      awaiting_in    = awaiting_ff;
      buf_b_in       = buf_b_ff;
      elapsed_in     = elapsed_ff;
      wait_in        = wait_ff;
      block_idx_in   = block_idx_ff;
      packet_idx_in  = packet_idx_ff;
      group_pos_in   = group_pos_ff;
      block_start_in = block_start_ff;
      next_due_in    = next_due_ff;
      last_fire_in   = last_fire_ff;
      sent_in        = sent_ff;
      ok_in          = ok_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      burst_in       = burst_ff;
      fire           = 1'b0;
      base_change    = 1'b0;
      finished       = 1'b0;
      ticked         = 1'b0;
      group_base     = group_pos_ff;
      packet_next    = {1'b0, packet_idx_ff} + 17'd1;
      elapsed_wide   = '0;

      if (step_en) begin
         if (cmd_t == CMD_START && !running_ff) begin
            running_in     = 1'b1;
            awaiting_in    = 1'b0;
            buf_b_in       = 1'b0;
            elapsed_in     = '0;
            block_start_in = '0;
            next_due_in    = '0;
            last_fire_in   = '0;
            wait_in        = '0;
            block_idx_in   = '0;
            packet_idx_in  = '0;
            group_pos_in   = '0;
            sent_in        = '0;
            ok_in          = '0;
            min_in         = NONE_MEASURED;
            max_in         = '0;
         end else if (cmd_t == CMD_DONE && running_ff && awaiting_ff) begin
            awaiting_in = 1'b0;
            if (tx_ok) begin
               ok_in = ok_ff + 32'd1;
            end
         end else if (cmd_t == CMD_TICK && running_ff) begin
            ticked = 1'b1;
            if (awaiting_ff) begin
               wait_in = (wait_ff != 16'hFFFF) ? wait_ff + 16'd1 : wait_ff;
               if (wait_in >= cfg.tx_timeout_us) begin
                  awaiting_in = 1'b0;
               end
            end
            if (!awaiting_in && block_idx_ff < cfg.block_count && !due_diff[TIME_BITS-1]) begin
               fire = 1'b1;
               if (packet_idx_ff != 16'd0) begin
                  if (gap32 < min_ff) min_in = gap32;
                  if (gap32 > max_ff) max_in = gap32;
               end
               last_fire_in = elapsed_ff;
               // swap buffers once the group is used up
               if (group_pos_ff >= group_size) begin
                  buf_b_in    = !buf_b_ff;
                  group_base  = 8'd0;
                  base_change = 1'b1;
               end
               group_pos_in = group_base + 8'd1;
               sent_in      = sent_ff + 32'd1;
               awaiting_in  = 1'b1;
               wait_in      = '0;
               next_due_in  = next_due_ff + TIME_BITS'(cfg.packet_interval_us);
               if (packet_next >= {1'b0, cfg.packets_in_block}) begin
                  packet_idx_in  = '0;
                  block_idx_in   = block_idx_ff + 16'd1;
                  block_start_in = block_start_ff + span_t;
                  next_due_in    = block_start_ff + span_t;
               end else begin
                  packet_idx_in = packet_next[15:0];
               end
            end
            elapsed_in = elapsed_ff + TIME_BITS'(1);
         end

         if (running_in && !awaiting_in && block_idx_in >= cfg.block_count) begin
            running_in   = 1'b0;
            finished     = 1'b1;
            elapsed_wide = ticked ? WIDE_BITS'(elapsed_ff) : WIDE_BITS'(elapsed_in);
            burst_in     = elapsed_wide[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         awaiting_ff    <= 1'b0;
         buf_b_ff       <= 1'b0;
         elapsed_ff     <= '0;
         wait_ff        <= '0;
         block_idx_ff   <= '0;
         packet_idx_ff  <= '0;
         group_pos_ff   <= '0;
         block_start_ff <= '0;
         next_due_ff    <= '0;
         last_fire_ff   <= '0;
         sent_ff        <= '0;
         ok_ff          <= '0;
         min_ff         <= NONE_MEASURED;
         max_ff         <= '0;
         burst_ff       <= '0;
      end else begin
         running_ff     <= running_in;
         awaiting_ff    <= awaiting_in;
         buf_b_ff       <= buf_b_in;
         elapsed_ff     <= elapsed_in;
         wait_ff        <= wait_in;
         block_idx_ff   <= block_idx_in;
         packet_idx_ff  <= packet_idx_in;
         group_pos_ff   <= group_pos_in;
         block_start_ff <= block_start_in;
         next_due_ff    <= next_due_in;
         last_fire_ff   <= last_fire_in;
         sent_ff        <= sent_in;
         ok_ff          <= ok_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         burst_ff       <= burst_in;
      end
   end

   assign result.fire          = fire;
   assign result.use_buffer_b  = buf_b_in;
   assign result.base_change   = base_change;
   assign result.busy_res      = running_in;
   assign result.finished      = finished;
   assign result.sent_count    = sent_in;
   assign result.ok_count      = ok_in;
   assign result.total_us      = burst_in;
   assign result.period_min_us = (min_in == NONE_MEASURED) ? 32'd0 : min_in;
   assign result.period_max_us = max_in;

endmodule

// ===== src/timed_packet_burst_sequencer_core.sv =====
// Top level: command beat register, burst state update and result register.
//
//   channel | dir | handshake          | payload
//   req     | in  | valid / ready      | cmd[1:0], tx_ok
//   rsp     | out | valid / ready      | fire .. period_max_us
//   csr     | in  | csr_we, csr_index  | csr_wdata[19:0]
//
// One command beat per cycle while results are taken; each beat waits in the beat
// register, goes through the combinational state update and then the result register.
// A stalled result holds the result register; the beat register still takes
// one more beat, then req ready drops until the result is taken.
// Synchronous reset restores the register defaults and clears the burst state.
module timed_packet_burst_sequencer_core
   import tpbs_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   tpbs_req_if.sink                  req_chan,
   tpbs_rsp_if.source                rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_cmd_ff;
   logic       in_tx_ok_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   rsp_type    step_result;
   cfg_type    cfg;
   logic       accept, advance;

   tpbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpbs_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cmd     (in_cmd_ff),
      .tx_ok   (in_tx_ok_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // advance the held beat when the result register is free or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff   <= req_chan.cmd;
         in_tx_ok_ff <= req_chan.tx_ok;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.fire          = out_ff.fire;
   assign rsp_chan.use_buffer_b  = out_ff.use_buffer_b;
   assign rsp_chan.base_change   = out_ff.base_change;
   assign rsp_chan.busy_res      = out_ff.busy_res;
   assign rsp_chan.finished      = out_ff.finished;
   assign rsp_chan.sent_count    = out_ff.sent_count;
   assign rsp_chan.ok_count      = out_ff.ok_count;
   assign rsp_chan.total_us      = out_ff.total_us;
   assign rsp_chan.period_min_us = out_ff.period_min_us;
   assign rsp_chan.period_max_us = out_ff.period_max_us;

endmodule

// ===== src/tpbs_checker.sv =====
// Port-level checks on result beats, bound to the top level.
module tpbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fire,
   input logic        rsp_base_change,
   input logic        rsp_busy_res,
   input logic        rsp_finished,
   input logic [31:0] rsp_sent_count,
   input logic [31:0] rsp_period_min_us,
   input logic [31:0] rsp_period_max_us
);

   // a fired packet leaves a transmit pending, so the burst cannot end with it
   a_fire_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fire |-> rsp_busy_res && !rsp_finished)
      else $error("fire without busy burst");

   a_finish_idles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_busy_res)
      else $error("finished while still busy");

   a_change_needs_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_base_change |-> rsp_fire)
      else $error("buffer change without fire");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_period_min_us <= rsp_period_max_us)
      else $error("minimum interval above maximum");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sent_count))
      else $error("stalled result beat changed");

endmodule

bind timed_packet_burst_sequencer_core tpbs_checker u_tpbs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_fire          (rsp_chan.fire),
   .rsp_base_change   (rsp_chan.base_change),
   .rsp_busy_res      (rsp_chan.busy_res),
   .rsp_finished      (rsp_chan.finished),
   .rsp_sent_count    (rsp_chan.sent_count),
   .rsp_period_min_us (rsp_chan.period_min_us),
   .rsp_period_max_us (rsp_chan.period_max_us)
);
